[hw/rtl/crf_pkg.sv]
`timescale 1ns / 1ps
package crf_pkg;

	localparam int COORD_W = 10;   // signed rectangle bounds
	localparam int EXT_W   = 11;   // bounds plus one bit of headroom for clipping
	localparam int SIZE_W  = 9;    // grid_size register
	localparam int NSIZE_W = 10;   // effective size, grid_size capped at GRID_MAX
	localparam int RC_W    = 8;    // read row and column

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_FILL  = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [SIZE_W-1:0] GRID_SIZE_RESET = 9'd256;

	typedef struct packed {
		logic load_fill;   // latch clipped rectangle, cursor to first row
		logic load_read;   // latch read cell and range flag
		logic ram_rd;      // read the row at the cursor
		logic wr_fill;     // write back the row with the column span set
		logic wr_clear;    // write a zero row at the cursor
		logic row_step;    // advance the cursor
		logic row_rst;     // return the cursor to zero
		logic emit_zero;   // finish a transaction with both fields zero
		logic emit_read;   // finish a read transaction from the row data
	} crf_cmd_t;

	typedef struct packed {
		logic fill_empty;  // clipped rectangle covers no cell
		logic row_last;    // cursor on the last row of the rectangle
		logic sweep_last;  // cursor on the last row of the store
		logic row_zero;    // cursor at zero
	} crf_stat_t;

endpackage

[hw/rtl/crf_ram.sv]
`timescale 1ns / 1ps
module crf_ram #(
	parameter int WIDTH = 256,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[hw/rtl/crf_dp.sv]
`timescale 1ns / 1ps
module crf_dp #(
	parameter int GRID_MAX = 256
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  crf_pkg::crf_cmd_t                       cmd,
	output crf_pkg::crf_stat_t                      st,
	input  logic signed [crf_pkg::COORD_W-1:0]      row_low,
	input  logic signed [crf_pkg::COORD_W-1:0]      row_high,
	input  logic signed [crf_pkg::COORD_W-1:0]      col_low,
	input  logic signed [crf_pkg::COORD_W-1:0]      col_high,
	input  logic [crf_pkg::RC_W-1:0]                read_row,
	input  logic [crf_pkg::RC_W-1:0]                read_col,
	input  logic                                    grid_size_wr_en,
	input  logic [crf_pkg::SIZE_W-1:0]              grid_size,
	output logic                                    done,
	output logic                                    cell_value,
	output logic                                    read_out_of_range
);
	import crf_pkg::*;

	localparam int AW = $clog2(GRID_MAX);
	localparam logic [NSIZE_W-1:0] GridMaxN = NSIZE_W'(GRID_MAX);
	localparam logic [AW-1:0] LastRow = AW'(GRID_MAX - 1);

	logic [SIZE_W-1:0]  grid_size_q;
	logic [NSIZE_W-1:0] n_eff;
	logic signed [EXT_W-1:0] n_m1, rl, rh, cl, ch, r0c, r1c, c0c, c1c;
	logic               empty_d, oor_d;
	logic [AW+RC_W-1:0] rr_ext, rc_ext;

	logic [AW-1:0] row_q, row_hi_q, col_lo_q, col_hi_q, col_q;
	logic          empty_q, oor_q;
	logic          done_q, cell_value_q, oor_out_q;

	logic [GRID_MAX-1:0] mask, rd_data, wr_data;
	logic                wr_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= GRID_SIZE_RESET;
		end else if (grid_size_wr_en) begin
			grid_size_q <= grid_size;
		end
	end

	// Clip the rectangle against the square in use and check the read cell against it.
	always_comb begin
		n_eff = ({1'b0, grid_size_q} > GridMaxN) ? GridMaxN : {1'b0, grid_size_q};
		n_m1  = $signed({1'b0, n_eff}) - $signed(EXT_W'(1));
		rl    = EXT_W'(row_low);
		rh    = EXT_W'(row_high);
		cl    = EXT_W'(col_low);
		ch    = EXT_W'(col_high);
		r0c   = (rl < 0) ? '0 : rl;
		c0c   = (cl < 0) ? '0 : cl;
		r1c   = (rh > n_m1) ? n_m1 : rh;
		c1c   = (ch > n_m1) ? n_m1 : ch;
		empty_d = (r0c > r1c) || (c0c > c1c);
		rr_ext = {{AW{1'b0}}, read_row};
		rc_ext = {{AW{1'b0}}, read_col};
		oor_d  = ({2'b00, read_row} >= n_eff) || ({2'b00, read_col} >= n_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (cmd.row_rst) begin
			row_q <= '0;
		end else if (cmd.load_fill) begin
			row_q <= r0c[AW-1:0];
		end else if (cmd.load_read) begin
			row_q <= oor_d ? '0 : rr_ext[AW-1:0];
		end else if (cmd.row_step) begin
			row_q <= row_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_fill) begin
			row_hi_q <= r1c[AW-1:0];
			col_lo_q <= c0c[AW-1:0];
			col_hi_q <= c1c[AW-1:0];
			empty_q  <= empty_d;
		end
		if (cmd.load_read) begin
			col_q <= oor_d ? '0 : rc_ext[AW-1:0];
			oor_q <= oor_d;
		end
	end

	always_comb begin
		for (int i = 0; i < GRID_MAX; i++) begin
			mask[i] = (AW'(i) >= col_lo_q) && (AW'(i) <= col_hi_q);
		end
	end

	assign wr_en   = cmd.wr_fill | cmd.wr_clear;
	assign wr_data = cmd.wr_clear ? '0 : (rd_data | mask);

	crf_ram #(
		.WIDTH(GRID_MAX),
		.DEPTH(GRID_MAX)
	) u_map (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (row_q),
		.wr_data (wr_data),
		.rd_en   (cmd.ram_rd),
		.rd_addr (row_q),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q       <= 1'b0;
			cell_value_q <= 1'b0;
			oor_out_q    <= 1'b0;
		end else begin
			done_q       <= cmd.emit_zero | cmd.emit_read;
			cell_value_q <= cmd.emit_read & ~oor_q & rd_data[col_q];
			oor_out_q    <= cmd.emit_read & oor_q;
		end
	end

	assign st.fill_empty = empty_q;
	assign st.row_last   = (row_q == row_hi_q);
	assign st.sweep_last = (row_q == LastRow);
	assign st.row_zero   = (row_q == '0);

	assign done              = done_q;
	assign cell_value        = cell_value_q;
	assign read_out_of_range = oor_out_q;

	a_quiet_without_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		!done_q |-> (!cell_value_q && !oor_out_q))
		else $error("result fields set without a strobe");

	a_no_fill_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_fill |-> !empty_q)
		else $error("row written for an empty rectangle");

	a_oor_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		oor_out_q |-> !cell_value_q)
		else $error("out-of-range read returned a set cell");

endmodule

[hw/rtl/crf_ctrl.sv]
`timescale 1ns / 1ps
module crf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         command,
	input  crf_pkg::crf_stat_t st,
	output crf_pkg::crf_cmd_t  cmd,
	output logic               busy
);
	import crf_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_FILL_RD,
		S_FILL_WR,
		S_READ_RD,
		S_READ_OUT
	} state_t;

	state_t state_q, state_d;
	logic   busy_q;
	logic   report_q, report_d;

	always_comb begin
		state_d  = state_q;
		report_d = report_q;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (command)
						CMD_CLEAR: state_d = S_CLEAR;
						CMD_FILL: begin
							cmd.load_fill = 1'b1;
							state_d       = S_FILL_RD;
						end
						CMD_READ: begin
							cmd.load_read = 1'b1;
							state_d       = S_READ_RD;
						end
						default: cmd.emit_zero = 1'b1;
					endcase
				end
			end
			S_CLEAR: begin
				cmd.wr_clear = 1'b1;
				if (st.sweep_last) begin
					// the sweep after reset answers nobody
					cmd.row_rst   = 1'b1;
					cmd.emit_zero = report_q;
					report_d      = 1'b1;
					state_d       = S_IDLE;
				end else begin
					cmd.row_step = 1'b1;
				end
			end
			S_FILL_RD: begin
				if (st.fill_empty) begin
					cmd.row_rst   = 1'b1;
					cmd.emit_zero = 1'b1;
					state_d       = S_IDLE;
				end else begin
					cmd.ram_rd = 1'b1;
					state_d    = S_FILL_WR;
				end
			end
			S_FILL_WR: begin
				cmd.wr_fill = 1'b1;
				if (st.row_last) begin
					cmd.row_rst   = 1'b1;
					cmd.emit_zero = 1'b1;
					state_d       = S_IDLE;
				end else begin
					cmd.row_step = 1'b1;
					state_d      = S_FILL_RD;
				end
			end
			S_READ_RD: begin
				cmd.ram_rd = 1'b1;
				state_d    = S_READ_OUT;
			end
			S_READ_OUT: begin
				cmd.emit_read = 1'b1;
				cmd.row_rst   = 1'b1;
				state_d       = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			busy_q   <= 1'b1;
			report_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			busy_q   <= (state_d != S_IDLE);
			report_q <= report_d;
		end
	end

	assign busy = busy_q;

	a_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_fill |-> $past(cmd.ram_rd))
		else $error("fill write-back without a row read");

	a_idle_cursor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> st.row_zero)
		else $error("cursor not returned to zero");

	a_busy_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (state_q != S_IDLE))
		else $error("busy raised while idle");

endmodule

[hw/rtl/clipped_rectangle_fill.sv]
`timescale 1ns / 1ps
// A read strobes done after reading the row; a fill that clips to nothing and an unused
// command strobe done with both result fields zero, and no map row is written.
// A fill row is a read-modify-write of one map row, so a rectangle costs a read and a
// write per clipped row whatever its width; a clear writes one zero row per cycle.
// After reset the map is swept to zero with busy high.
// Results are strobed for one cycle; the receiver cannot stall.
module clipped_rectangle_fill #(
	parameter int GRID_MAX = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         command,
	input  logic signed [crf_pkg::COORD_W-1:0] row_low,
	input  logic signed [crf_pkg::COORD_W-1:0] row_high,
	input  logic signed [crf_pkg::COORD_W-1:0] col_low,
	input  logic signed [crf_pkg::COORD_W-1:0] col_high,
	input  logic [crf_pkg::RC_W-1:0]           read_row,
	input  logic [crf_pkg::RC_W-1:0]           read_col,
	input  logic                               grid_size_wr_en,
	input  logic [crf_pkg::SIZE_W-1:0]         grid_size,
	output logic                               done,
	output logic                               cell_value,
	output logic                               read_out_of_range
);
	import crf_pkg::*;

	crf_cmd_t  cmd;
	crf_stat_t st;

	crf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.st      (st),
		.cmd     (cmd),
		.busy    (busy)
	);

	crf_dp #(
		.GRID_MAX(GRID_MAX)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.st                (st),
		.row_low           (row_low),
		.row_high          (row_high),
		.col_low           (col_low),
		.col_high          (col_high),
		.read_row          (read_row),
		.read_col          (read_col),
		.grid_size_wr_en   (grid_size_wr_en),
		.grid_size         (grid_size),
		.done              (done),
		.cell_value        (cell_value),
		.read_out_of_range (read_out_of_range)
	);

endmodule
